// ===== sv/pmhc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmhc_pkg
// Shared constants and types for the projected point mask hit counter.
// ----------------------------------------------------------------------------
package pmhc_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_POINTS = 1048576;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;
  localparam int PIX_W      = 24;
  localparam int CNT_W      = 21;
  localparam int FRAC_W     = 17;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_W      = 64;
  localparam int ACC_W      = 50;
  localparam int DIV_W      = 49;
  localparam int SUM_LIMIT  = 55 * 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A = 4'd0,
    REG_ROW0_B = 4'd1,
    REG_ROW1_A = 4'd2,
    REG_ROW1_B = 4'd3,
    REG_ROW2_A = 4'd4,
    REG_ROW2_B = 4'd5,
    REG_WIDTH  = 4'd6,
    REG_HEIGHT = 4'd7
  } cfg_reg_t;

endpackage

// ===== sv/pmhc_ram.sv =====
// ----------------------------------------------------------------------------
// pmhc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pmhc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pmhc_div.sv =====
// ----------------------------------------------------------------------------
// pmhc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmhc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pmhc_pkg::DIV_W-1:0] num,
  input  logic [pmhc_pkg::DIV_W-1:0] den,
  output logic                       done,
  output logic [pmhc_pkg::DIV_W-1:0] quo,
  output logic [pmhc_pkg::DIV_W-1:0] rem
);
  import pmhc_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, rem_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/projected_point_mask_hit_counter.sv =====
// ----------------------------------------------------------------------------
// projected_point_mask_hit_counter
// Image store fill, point projection, mask lookup and hit statistics.
// ----------------------------------------------------------------------------
// channel | handshake            | carries
// in_     | in_valid / in_ready  | pixel write or 3D point
// out_    | out_valid / out_ready| hit count, total count, hit fraction
// cfg_    | cfg_valid / cfg_ready| register index and 64-bit data
//
// A valid point that lands in the image passes through the multiply steps, a
// depth check, two divisions through the shared divider, the image store read
// and a finish step. One that lands outside the image skips the store read,
// one without positive depth also skips the divisions, and an invalid point
// goes straight to the finish step. The last point adds a fraction division
// through the same divider and an output step.
// The image store has no reset; the tallies clear on reset and after a result.
// A result waits in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module projected_point_mask_hit_counter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [9:0]                     in_pixel_col,
  input  logic [9:0]                     in_pixel_row,
  input  logic [7:0]                     in_chan_blue,
  input  logic [7:0]                     in_chan_green,
  input  logic [7:0]                     in_chan_red,
  input  logic signed [31:0]             in_coord_x,
  input  logic signed [31:0]             in_coord_y,
  input  logic signed [31:0]             in_coord_z,
  input  logic                           in_coord_valid,
  input  logic                           in_last_point,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pmhc_pkg::CNT_W-1:0]     out_hit_count,
  output logic [pmhc_pkg::CNT_W-1:0]     out_total_count,
  output logic [pmhc_pkg::FRAC_W-1:0]    out_hit_fraction,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmhc_pkg::CFG_W-1:0]     cfg_data
);
  import pmhc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WCHK, S_DIVU, S_DIVV, S_RD, S_RDW, S_FIN, S_FRAC, S_OUT
  } state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  r0a_r, r0b_r, r1a_r, r1b_r, r2a_r, r2b_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [CNT_W-1:0]  hit_r, total_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic              valid_r, last_r;
  logic [3:0]        idx_r, pidx_r;
  logic              pvalid_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] u_r, v_r, w_r;
  logic              uneg_r;
  logic [COL_W-1:0]  px_r;
  logic              pxok_r;
  logic [ROW_W-1:0]  py_r;
  logic              div_start_r;
  logic [DIV_W-1:0]  div_num_r, div_den_r;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo, div_rem;
  logic [FRAC_W-1:0] frac_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_hit_r, out_total_r;
  logic [FRAC_W-1:0] out_frac_r;

  logic              accept, pix_we;
  logic signed [31:0] coef, coord;
  logic signed [ACC_W-1:0] term;
  logic [DIV_W:0]    two_rem, qr;
  logic              rnd, qneg;
  logic [SIZE_W-1:0] wlim, hlim;
  logic              in_col, in_row;
  logic [PIX_W-1:0]  pix;
  logic [9:0]        chan_sum;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign pix_we    = accept && !in_mode &&
                     (32'(in_pixel_col) < 32'(MAX_COLS)) &&
                     (32'(in_pixel_row) < 32'(MAX_ROWS));

  pmhc_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (pix_we),
    .waddr ({in_pixel_row[ROW_W-1:0], in_pixel_col[COL_W-1:0]}),
    .wdata ({in_chan_red, in_chan_green, in_chan_blue}),
    .raddr ({py_r, px_r}),
    .rdata (pix)
  );

  pmhc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    coef  = '0;
    coord = '0;
    unique case (idx_r)
      4'd0:    begin coef = r2a_r[31:0];  coord = x_r; end
      4'd1:    begin coef = r2a_r[63:32]; coord = y_r; end
      4'd2:    begin coef = r2b_r[31:0];  coord = z_r; end
      4'd3:    begin coef = r0a_r[31:0];  coord = x_r; end
      4'd4:    begin coef = r0a_r[63:32]; coord = y_r; end
      4'd5:    begin coef = r0b_r[31:0];  coord = z_r; end
      4'd6:    begin coef = r1a_r[31:0];  coord = x_r; end
      4'd7:    begin coef = r1a_r[63:32]; coord = y_r; end
      4'd8:    begin coef = r1b_r[31:0];  coord = z_r; end
      default: begin coef = '0;           coord = '0;  end
    endcase
  end

  assign term = ACC_W'(prod_r >>> 16);

  assign two_rem = {div_rem, 1'b0};
  assign rnd     = (two_rem > {1'b0, div_den_r}) ||
                   ((two_rem == {1'b0, div_den_r}) && div_quo[0]);
  assign qr      = {1'b0, div_quo} + (DIV_W+1)'(rnd);
  assign qneg    = (state_r == S_DIVU) ? uneg_r : v_r[ACC_W-1];
  assign wlim    = (32'(width_r)  > 32'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width_r;
  assign hlim    = (32'(height_r) > 32'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height_r;
  assign in_col  = (!qneg || qr == '0) && (qr < (DIV_W+1)'(wlim));
  assign in_row  = (!qneg || qr == '0) && (qr < (DIV_W+1)'(hlim));
  assign chan_sum = 10'(pix[7:0]) + 10'(pix[15:8]) + 10'(pix[23:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      r0a_r <= '0; r0b_r <= '0; r1a_r <= '0; r1b_r <= '0; r2a_r <= '0; r2b_r <= '0;
      width_r     <= SIZE_W'(1024);
      height_r    <= SIZE_W'(1024);
      hit_r       <= '0;
      total_r     <= '0;
      div_start_r <= 1'b0;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROW0_A: r0a_r <= cfg_data;
          REG_ROW0_B: r0b_r <= cfg_data;
          REG_ROW1_A: r1a_r <= cfg_data;
          REG_ROW1_B: r1b_r <= cfg_data;
          REG_ROW2_A: r2a_r <= cfg_data;
          REG_ROW2_B: r2b_r <= cfg_data;
          REG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_mode) begin
            if (32'(total_r) < 32'(MAX_POINTS)) begin
              total_r <= total_r + 1'b1;
            end
            x_r      <= in_coord_x;
            y_r      <= in_coord_y;
            z_r      <= in_coord_z;
            valid_r  <= in_coord_valid;
            last_r   <= in_last_point;
            w_r      <= ACC_W'(signed'(r2b_r[63:32]));
            u_r      <= ACC_W'(signed'(r0b_r[63:32]));
            v_r      <= ACC_W'(signed'(r1b_r[63:32]));
            idx_r    <= '0;
            pvalid_r <= 1'b0;
            state_r  <= in_coord_valid ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          prod_r   <= coef * coord;
          pidx_r   <= idx_r;
          pvalid_r <= (idx_r < 4'd9);
          idx_r    <= idx_r + 1'b1;
          if (pvalid_r) begin
            if (pidx_r < 4'd3) begin
              w_r <= w_r + term;
            end else if (pidx_r < 4'd6) begin
              u_r <= u_r + term;
            end else begin
              v_r <= v_r + term;
            end
          end
          if (idx_r == 4'd9) begin
            state_r <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (!w_r[ACC_W-1] && w_r != '0) begin
            uneg_r      <= u_r[ACC_W-1];
            div_num_r   <= DIV_W'(u_r[ACC_W-1] ? -u_r : u_r);
            div_den_r   <= DIV_W'(w_r);
            div_start_r <= 1'b1;
            state_r     <= S_DIVU;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DIVU: begin
          if (div_done) begin
            px_r        <= qr[COL_W-1:0];
            pxok_r      <= in_col;
            div_num_r   <= DIV_W'(v_r[ACC_W-1] ? -v_r : v_r);
            div_start_r <= 1'b1;
            state_r     <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            py_r    <= qr[ROW_W-1:0];
            state_r <= (pxok_r && in_row) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          if (32'(chan_sum) > 32'(SUM_LIMIT) && 32'(hit_r) < 32'(MAX_POINTS)) begin
            hit_r <= hit_r + 1'b1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (last_r) begin
            div_num_r   <= DIV_W'({hit_r, 16'd0});
            div_den_r   <= DIV_W'(total_r);
            div_start_r <= 1'b1;
            state_r     <= S_FRAC;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FRAC: begin
          if (div_done) begin
            frac_r  <= (total_r == '0) ? '0 :
                       (div_quo > DIV_W'(65536)) ? FRAC_W'(65536) :
                       div_quo[FRAC_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_r;
            out_total_r <= total_r;
            out_frac_r  <= frac_r;
            hit_r       <= '0;
            total_r     <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_count    = out_hit_r;
  assign out_total_count  = out_total_r;
  assign out_hit_fraction = out_frac_r;

endmodule

// ===== sv/pmhc_checker.sv =====
// ----------------------------------------------------------------------------
// pmhc_checker
// Port-level checks on the result channel of the hit counter.
// ----------------------------------------------------------------------------
module pmhc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pmhc_pkg::CNT_W-1:0]       out_hit_count,
  input logic [pmhc_pkg::CNT_W-1:0]       out_total_count,
  input logic [pmhc_pkg::FRAC_W-1:0]      out_hit_fraction
);
  import pmhc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_count))
    else $error("result dropped while stalled");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_count <= out_total_count && out_total_count != '0)
    else $error("hit count above total");

  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_fraction <= FRAC_W'(65536))
    else $error("fraction above one");

  a_frac_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_count == out_total_count |-> out_hit_fraction == FRAC_W'(65536))
    else $error("full hit fraction wrong");

endmodule

bind projected_point_mask_hit_counter pmhc_checker u_pmhc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit_count    (out_hit_count),
  .out_total_count  (out_total_count),
  .out_hit_fraction (out_hit_fraction)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the projected point mask hit counter. An in-bench
// tally model mirrors the image store, the projection and the hit counting,
// and each result is compared with the oldest predicted tally. Phases of
// projection and image size settings drive pixel fills, aimed and random
// points, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import pmhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam longint ONE = 64'sd65536;

  typedef struct {
    bit               mode;
    bit [9:0]         col;
    bit [9:0]         row;
    bit [7:0]         blue;
    bit [7:0]         green;
    bit [7:0]         red;
    bit signed [31:0] x;
    bit signed [31:0] y;
    bit signed [31:0] z;
    bit               cv;
    bit               last;
  } pmhc_item_t;

  typedef struct {
    bit [CNT_W-1:0]  hits;
    bit [CNT_W-1:0]  total;
    bit [FRAC_W-1:0] frac;
  } tally_t;

  class hit_scoreboard;
    bit [CFG_W-1:0]  coef[6];
    bit [SIZE_W-1:0] width_reg;
    bit [SIZE_W-1:0] height_reg;
    bit [PIX_W-1:0]  image[int];
    int              hit_tally;
    int              point_tally;
    tally_t          pending[$];
    int              errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] v);
      if (idx <= REG_ROW2_B) coef[idx] = v;
      else if (idx == REG_WIDTH) width_reg = v[SIZE_W-1:0];
      else if (idx == REG_HEIGHT) height_reg = v[SIZE_W-1:0];
    endfunction

    function longint project(int r, pmhc_item_t it);
      longint c0, c1, c2, c3;
      c0 = longint'($signed(coef[2*r][31:0]));
      c1 = longint'($signed(coef[2*r][63:32]));
      c2 = longint'($signed(coef[2*r+1][31:0]));
      c3 = longint'($signed(coef[2*r+1][63:32]));
      return ((c0 * longint'(it.x)) >>> 16) + ((c1 * longint'(it.y)) >>> 16)
           + ((c2 * longint'(it.z)) >>> 16) + c3;
    endfunction

    function longint div_even(longint n, longint d);
      longint mag, q, r;
      mag = (n < 0) ? -n : n;
      q = mag / d;
      r = mag % d;
      if (2 * r > d || (2 * r == d && q[0])) q++;
      return (n < 0) ? -q : q;
    endfunction

    // image address read by a point, or -1 when none is read
    function int pixel_index(pmhc_item_t it);
      longint w, px, py, wl, hl;
      if (!it.mode || !it.cv) return -1;
      w = project(2, it);
      if (w <= 0) return -1;
      px = div_even(project(0, it), w);
      py = div_even(project(1, it), w);
      wl = (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
      hl = (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
      if (px < 0 || px >= wl || py < 0 || py >= hl) return -1;
      return int'(py) * MAX_COLS + int'(px);
    endfunction

    function bit safe(pmhc_item_t it);
      int idx;
      idx = pixel_index(it);
      return idx < 0 || image.exists(idx);
    endfunction

    function void note_input(pmhc_item_t it);
      int idx;
      bit [PIX_W-1:0] pix;
      int sum;
      tally_t t;
      if (!it.mode) begin
        image[int'(it.row) * MAX_COLS + int'(it.col)] = {it.red, it.green, it.blue};
        return;
      end
      if (point_tally < MAX_POINTS) point_tally++;
      idx = pixel_index(it);
      if (idx >= 0) begin
        pix = image.exists(idx) ? image[idx] : '0;
        sum = pix[7:0] + pix[15:8] + pix[23:16];
        if (sum > SUM_LIMIT && hit_tally < MAX_POINTS) hit_tally++;
      end
      if (!it.last) return;
      t.hits = CNT_W'(hit_tally);
      t.total = CNT_W'(point_tally);
      t.frac = ((longint'(hit_tally) << 16) / point_tally > 65536) ? FRAC_W'(65536) :
               FRAC_W'((longint'(hit_tally) << 16) / point_tally);
      pending.push_back(t);
      hit_tally = 0;
      point_tally = 0;
    endfunction

    function void check_result(tally_t got);
      tally_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hits=%0d total=%0d frac=%0d",
                                   got.hits, got.total, got.frac);
        return;
      end
      want = pending.pop_front();
      if (got.hits !== want.hits || got.total !== want.total || got.frac !== want.frac) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hits=%0d total=%0d frac=%0d, got %0d %0d %0d",
                   want.hits, want.total, want.frac, got.hits, got.total, got.frac);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = 1'b0;
  logic [9:0]           in_pixel_col = '0;
  logic [9:0]           in_pixel_row = '0;
  logic [7:0]           in_chan_blue = '0;
  logic [7:0]           in_chan_green = '0;
  logic [7:0]           in_chan_red = '0;
  logic signed [31:0]   in_coord_x = '0;
  logic signed [31:0]   in_coord_y = '0;
  logic signed [31:0]   in_coord_z = '0;
  logic                 in_coord_valid = 1'b0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     out_hit_count;
  logic [CNT_W-1:0]     out_total_count;
  logic [FRAC_W-1:0]    out_hit_fraction;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  hit_scoreboard tally_sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;
  int fill_w, fill_h, cloud_left;
  int scale, trans0, trans1;

  projected_point_mask_hit_counter i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check, random stalls, one long hold-off on request
  initial begin
    int hold;
    tally_t got;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.hits = out_hit_count;
        got.total = out_total_count;
        got.frac = out_hit_fraction;
        tally_sb.check_result(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || $urandom_range(0, 99) >= 35;
      end
    end
  end

  task automatic send(pmhc_item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_pixel_col <= it.col;
    in_pixel_row <= it.row;
    in_chan_blue <= it.blue;
    in_chan_green <= it.green;
    in_chan_red <= it.red;
    in_coord_x <= it.x;
    in_coord_y <= it.y;
    in_coord_z <= it.z;
    in_coord_valid <= it.cv;
    in_last_point <= it.last;
    do @(posedge clk); while (!in_ready);
    tally_sb.note_input(it);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tally_sb.set_reg(idx, v);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tally_sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic pmhc_item_t pixel(int c, int r, int b, int g, int rd);
    pmhc_item_t it;
    it = '{default: 0};
    it.mode = 1'b0;
    it.col = 10'(c);
    it.row = 10'(r);
    it.blue = 8'(b);
    it.green = 8'(g);
    it.red = 8'(rd);
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.cv = 1'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic pmhc_item_t rand_pixel(int c, int r);
    if ($urandom_range(0, 1)) return pixel(c, r, $urandom, $urandom, $urandom);
    return pixel(c, r, $urandom_range(0, 110), $urandom_range(0, 110), $urandom_range(0, 110));
  endfunction

  // point aimed at column tc and row tr, jitter in units of z/2
  function automatic pmhc_item_t aimed(int tc, int tr, int jit);
    pmhc_item_t it;
    longint z;
    it = '{default: 0};
    it.mode = 1'b1;
    it.cv = 1'b1;
    z = longint'($urandom_range(1, 8)) << 16;
    if ($urandom_range(0, 1)) z += $urandom_range(0, 65535);
    it.z = 32'(z);
    it.x = 32'(((longint'(tc) * z + (jit * z) / 2 - trans0) * ONE) / scale);
    it.y = 32'(((longint'(tr) * z + (jit * z) / 2 - trans1) * ONE) / scale);
    return it;
  endfunction

  function automatic pmhc_item_t noise_point();
    pmhc_item_t it;
    it = '{default: 0};
    it.mode = 1'b1;
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.cv = $urandom_range(0, 9) != 0;
    return it;
  endfunction

  task automatic send_point(pmhc_item_t it);
    int tries;
    tries = 0;
    while (!tally_sb.safe(it) && tries < 8) begin
      it = noise_point();
      tries++;
    end
    if (!tally_sb.safe(it)) it.cv = 1'b0;
    if (cloud_left <= 0) cloud_left = $urandom_range(1, 24);
    cloud_left--;
    it.last = cloud_left == 0;
    send(it);
  endtask

  task automatic aim_config(int w, int h, int s, int t0, int t1);
    scale = s;
    trans0 = t0;
    trans1 = t1;
    write_reg(REG_ROW0_A, {32'h0, s[31:0]});
    write_reg(REG_ROW0_B, {t0[31:0], 32'h0});
    write_reg(REG_ROW1_A, {s[31:0], 32'h0});
    write_reg(REG_ROW1_B, {t1[31:0], 32'h0});
    write_reg(REG_ROW2_A, 64'h0);
    write_reg(REG_ROW2_B, {32'h0, 32'h0001_0000});
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  task automatic fill(int w, int h);
    fill_w = (w < 1) ? 4 : (w > 8 ? 8 : w);
    fill_h = (h < 1) ? 4 : (h > 8 ? 8 : h);
    for (int r = 0; r < fill_h; r++)
      for (int c = 0; c < fill_w; c++) send(rand_pixel(c, r));
  endtask

  task automatic point_run(int n, int aim_pct);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) send(rand_pixel($urandom_range(0, 1023), $urandom_range(0, 1023)));
      else if (roll < 5 + aim_pct)
        send_point(aimed($urandom_range(0, fill_w - 1), $urandom_range(0, fill_h - 1),
                         int'($urandom_range(0, 4)) - 2));
      else send_point(noise_point());
    end
  endtask

  task automatic aim_phase(int w, int h, int s, int t0, int t1, int n);
    settle();
    aim_config(w, h, s, t0, t1);
    cfg_valid <= 1'b0;
    fill(w, h);
    point_run(n, 85);
  endtask

  task automatic raw_phase(bit [CFG_W-1:0] r0, bit [CFG_W-1:0] r1, int w, int h, int n);
    settle();
    write_reg(REG_ROW0_A, r0);
    write_reg(REG_ROW0_B, r1);
    write_reg(REG_ROW1_A, ~r0);
    write_reg(REG_ROW1_B, r1 ^ {$urandom, $urandom});
    write_reg(REG_ROW2_A, r0 ^ r1);
    write_reg(REG_ROW2_B, {$urandom, $urandom});
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    cfg_valid <= 1'b0;
    point_run(n, 0);
  endtask

  task automatic directed();
    pmhc_item_t it;
    send(pixel(0, 0, 100, 66, 0));
    send(pixel(1, 0, 100, 65, 0));
    send(pixel(1023, 1023, 255, 255, 255));
    send(pixel(0, 1023, 0, 0, 0));
    send(aimed(0, 0, 0));
    send(aimed(1, 0, 0));
    it = aimed(0, 0, 0);
    it.cv = 1'b0;
    send(it);
    it = aimed(2, 2, 0);
    it.z = -it.z;
    send(it);
    it = aimed(2, 2, 0);
    it.z = 0;
    send(it);
    send(aimed(12, 0, 0));
    send(aimed(0, -1, 0));
    send(aimed(0, 0, 1));
    send(aimed(1, 1, 1));
    it = pixel(1023, 1023, 255, 255, 255);
    it.last = 1'b1;
    send(it);
    it = aimed(2, 1, 0);
    it.last = 1'b1;
    send(it);
  endtask

  initial begin
    cloud_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    aim_config(12, 10, 65536, 0, 0);
    cfg_valid <= 1'b0;
    fill(12, 10);
    directed();
    point_run(100, 85);
    aim_phase(16, 8, 131072, 229376, -131072, 100);
    aim_phase(1, 1, 32768, 0, 0, 80);
    aim_phase(0, 5, 65536, 0, 0, 60);
    aim_phase(2047, 1024, 65536, 0, 0, 100);
    aim_phase(8, 8, -65536, 65536, 0, 100);
    settle();
    for (int i = 8; i < 16; i++) write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    quiet = 1'b1;
    point_run(150, 85);
    quiet = 1'b0;
    settle();
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      cloud_left = 1;
      send_point(aimed($urandom_range(0, fill_w - 1), $urandom_range(0, fill_h - 1), 0));
    end
    raw_phase({$urandom, $urandom}, {$urandom, $urandom},
              $urandom_range(1, 1024), $urandom_range(1, 1024), 100);
    raw_phase({64{1'b1}}, {64{1'b1}}, 1024, 1024, 60);
    raw_phase(64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF, 1, 1024, 60);
    aim_phase(12, 10, 65536, -32768, 32768, 150);
    settle();
    if (tally_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== projected_point_mask_hit_counter.f =====
sv/pmhc_pkg.sv
sv/pmhc_ram.sv
sv/pmhc_div.sv
sv/projected_point_mask_hit_counter.sv
sv/pmhc_checker.sv
bench/tb_top.sv
